// ===== rtl/core/swad_pkg.sv =====
package swad_pkg;

  localparam int LETTER_W = 5;

  localparam logic [1:0] ACT_CLEAR   = 2'd0;
  localparam logic [1:0] ACT_PATTERN = 2'd1;
  localparam logic [1:0] ACT_TEXT    = 2'd2;

  typedef struct packed {
    logic [1:0]          action;
    logic [LETTER_W-1:0] letter;
  } item_t;

  typedef struct packed {
    logic window_match;
    logic found_any;
    logic pattern_overflow;
  } result_t;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_HOLD    = 3'd2,
    OP_PATTERN = 3'd3,
    OP_ENTER   = 3'd4,
    OP_SLIDE   = 3'd5
  } op_t;

  typedef struct packed {
    op_t  op;
    logic overflow;
  } ctl_t;

endpackage

// ===== rtl/core/swad_ram.sv =====
module swad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/swad_front.sv =====
module swad_front #(
  parameter int MAX_PATTERN = 64,
  parameter int ALPHABET    = 26
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  logic                               accept,
  input  swad_pkg::item_t                    item,
  output logic                               s1_valid,
  output swad_pkg::ctl_t                     s1_ctl,
  output logic [$clog2(ALPHABET)-1:0]        s1_bin,
  output logic [$clog2(ALPHABET)-1:0]        s1_old
);

  localparam int BIN_W   = $clog2(ALPHABET);
  localparam int RING_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int EXT_W   = ((swad_pkg::LETTER_W > BIN_W) ? swad_pkg::LETTER_W : BIN_W) + 1;

  logic [LEN_W-1:0]   pattern_len, pattern_len_next;
  logic [LEN_W-1:0]   window_fill, window_fill_next;
  logic [RING_AW-1:0] ring_head, ring_head_next;
  logic               overflow, overflow_next;
  logic [EXT_W-1:0]   letter_ext;
  logic               letter_ok;
  logic [BIN_W-1:0]   letter_bin;
  logic [RING_AW:0]   slot_sum;
  logic [RING_AW-1:0] slot;
  logic [RING_AW-1:0] head_inc;
  swad_pkg::ctl_t     ctl_next;
  logic [BIN_W-1:0]   bin_next;
  logic               ring_we, ring_re;
  logic [BIN_W-1:0]   ring_rdata;

  assign letter_ext = EXT_W'(item.letter);
  assign letter_ok  = letter_ext < EXT_W'(ALPHABET);
  assign letter_bin = letter_ext[BIN_W-1:0];

  assign slot_sum = (RING_AW+1)'(ring_head) + (RING_AW+1)'(window_fill);
  assign slot = (slot_sum >= (RING_AW+1)'(MAX_PATTERN)) ?
                RING_AW'(slot_sum - (RING_AW+1)'(MAX_PATTERN)) : RING_AW'(slot_sum);
  assign head_inc = (ring_head == RING_AW'(MAX_PATTERN - 1)) ? '0 : ring_head + 1'b1;

  always_comb begin
    pattern_len_next = pattern_len;
    window_fill_next = window_fill;
    ring_head_next   = ring_head;
    overflow_next    = overflow;
    ctl_next.op      = swad_pkg::OP_NONE;
    bin_next         = '0;
    ring_we          = 1'b0;
    ring_re          = 1'b0;
    case (item.action)
      swad_pkg::ACT_CLEAR: begin
        pattern_len_next = '0;
        window_fill_next = '0;
        ring_head_next   = '0;
        overflow_next    = 1'b0;
        ctl_next.op      = swad_pkg::OP_CLEAR;
      end
      swad_pkg::ACT_PATTERN: begin
        if (letter_ok) begin
          if (pattern_len == LEN_W'(MAX_PATTERN)) begin
            overflow_next = 1'b1;
            ctl_next.op   = swad_pkg::OP_HOLD;
          end else begin
            pattern_len_next = pattern_len + 1'b1;
            ctl_next.op      = swad_pkg::OP_PATTERN;
            bin_next         = letter_bin;
          end
        end
      end
      swad_pkg::ACT_TEXT: begin
        if (letter_ok) begin
          bin_next = letter_bin;
          if (pattern_len == '0) begin
            ctl_next.op = swad_pkg::OP_HOLD;
          end else begin
            ring_we = 1'b1;
            if (window_fill == pattern_len) begin
              ctl_next.op    = swad_pkg::OP_SLIDE;
              ring_re        = 1'b1;
              ring_head_next = head_inc;
            end else begin
              ctl_next.op      = swad_pkg::OP_ENTER;
              window_fill_next = window_fill + 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    ctl_next.overflow = overflow_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len <= '0;
      window_fill <= '0;
      ring_head   <= '0;
      overflow    <= 1'b0;
      s1_valid    <= 1'b0;
    end else begin
      if (accept) begin
        pattern_len <= pattern_len_next;
        window_fill <= window_fill_next;
        ring_head   <= ring_head_next;
        overflow    <= overflow_next;
      end
      if (advance) begin
        s1_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ctl <= ctl_next;
      s1_bin <= bin_next;
    end
  end

  swad_ram #(
    .WIDTH (BIN_W),
    .DEPTH (MAX_PATTERN)
  ) u_ring (
    .clk   (clk),
    .we    (accept && ring_we),
    .waddr (slot),
    .wdata (bin_next),
    .re    (accept && ring_re),
    .raddr (ring_head),
    .rdata (ring_rdata)
  );

  assign s1_old = (s1_ctl.op == swad_pkg::OP_SLIDE) ? ring_rdata : s1_bin;

endmodule

// ===== rtl/core/swad_hist.sv =====
module swad_hist #(
  parameter int MAX_PATTERN = 64,
  parameter int ALPHABET    = 26
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        s1_valid,
  input  swad_pkg::ctl_t              s1_ctl,
  input  logic [$clog2(ALPHABET)-1:0] s1_bin,
  input  logic [$clog2(ALPHABET)-1:0] s1_old,
  output logic                        s2_valid,
  output swad_pkg::result_t           res
);

  localparam int BIN_W = $clog2(ALPHABET);
  localparam int CNT_W = $clog2(MAX_PATTERN + 1) + 1;
  localparam int MIS_W = $clog2(ALPHABET + 1);

  swad_pkg::ctl_t    s2_ctl;
  logic [BIN_W-1:0]  s2_bin, s2_old;
  logic [BIN_W-1:0]  rd_c, rd_o;
  logic [MIS_W-1:0]  mismatch, mismatch_new;
  logic              found, found_new;
  logic [ALPHABET-1:0] net_vld, drop_vld;

  logic              byp_net_v, byp_drop_v;
  logic [BIN_W-1:0]  byp_net_addr, byp_drop_addr;
  logic [CNT_W-1:0]  byp_net_data, byp_drop_data;

  logic [CNT_W-1:0]  net_c_rdata, net_o_rdata, drop_c_rdata, drop_o_rdata;
  logic [CNT_W-1:0]  net_c, net_o, drop_c, drop_o;
  logic [CNT_W-1:0]  d_c, d_o;
  logic [CNT_W-1:0]  net_wdata, drop_wdata;
  logic              net_we, drop_we, commit;
  logic              use_c, use_o, pre_c, pre_o, post_c, post_o;

  assign commit = s2_valid && advance;
  assign rd_c   = advance ? s1_bin : s2_bin;
  assign rd_o   = advance ? s1_old : s2_old;

  assign net_c  = (byp_net_v && byp_net_addr == s2_bin) ? byp_net_data :
                  (net_vld[s2_bin] ? net_c_rdata : '0);
  assign net_o  = (byp_net_v && byp_net_addr == s2_old) ? byp_net_data :
                  (net_vld[s2_old] ? net_o_rdata : '0);
  assign drop_c = (byp_drop_v && byp_drop_addr == s2_bin) ? byp_drop_data :
                  (drop_vld[s2_bin] ? drop_c_rdata : '0);
  assign drop_o = (byp_drop_v && byp_drop_addr == s2_old) ? byp_drop_data :
                  (drop_vld[s2_old] ? drop_o_rdata : '0);

  assign d_c   = net_c - drop_c;
  assign d_o   = net_o - drop_o;
  assign pre_c = d_c != '0;
  assign pre_o = d_o != '0;

  always_comb begin
    net_wdata  = net_c + CNT_W'(1);
    drop_wdata = drop_o + CNT_W'(1);
    net_we     = 1'b0;
    drop_we    = 1'b0;
    use_c      = 1'b0;
    use_o      = 1'b0;
    post_c     = pre_c;
    post_o     = pre_o;
    case (s2_ctl.op)
      swad_pkg::OP_PATTERN: begin
        net_wdata = net_c - CNT_W'(1);
        net_we    = 1'b1;
        use_c     = 1'b1;
        post_c    = (d_c - CNT_W'(1)) != '0;
      end
      swad_pkg::OP_ENTER: begin
        net_we = 1'b1;
        use_c  = 1'b1;
        post_c = (d_c + CNT_W'(1)) != '0;
      end
      swad_pkg::OP_SLIDE: begin
        net_we  = 1'b1;
        drop_we = 1'b1;
        if (s2_old != s2_bin) begin
          use_c  = 1'b1;
          use_o  = 1'b1;
          post_c = (d_c + CNT_W'(1)) != '0;
          post_o = (d_o - CNT_W'(1)) != '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (s2_ctl.op == swad_pkg::OP_CLEAR) begin
      mismatch_new = '0;
      found_new    = 1'b0;
    end else begin
      mismatch_new = mismatch + MIS_W'(use_c & post_c) + MIS_W'(use_o & post_o)
                   - MIS_W'(use_c & pre_c) - MIS_W'(use_o & pre_o);
      if (s2_ctl.op == swad_pkg::OP_NONE) begin
        found_new = found;
      end else begin
        found_new = found | (mismatch_new == '0);
      end
    end
  end

  assign res.window_match     = mismatch_new == '0;
  assign res.found_any        = found_new;
  assign res.pattern_overflow = s2_ctl.overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid   <= 1'b0;
      mismatch   <= '0;
      found      <= 1'b0;
      net_vld    <= '0;
      drop_vld   <= '0;
      byp_net_v  <= 1'b0;
      byp_drop_v <= 1'b0;
    end else begin
      if (advance) begin
        s2_valid <= s1_valid;
      end
      byp_net_v  <= commit && net_we;
      byp_drop_v <= commit && drop_we;
      if (commit) begin
        mismatch <= mismatch_new;
        found    <= found_new;
        if (s2_ctl.op == swad_pkg::OP_CLEAR) begin
          net_vld  <= '0;
          drop_vld <= '0;
        end else begin
          if (net_we) begin
            net_vld[s2_bin] <= 1'b1;
          end
          if (drop_we) begin
            drop_vld[s2_old] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_ctl <= s1_ctl;
      s2_bin <= s1_bin;
      s2_old <= s1_old;
    end
    byp_net_addr  <= s2_bin;
    byp_net_data  <= net_wdata;
    byp_drop_addr <= s2_old;
    byp_drop_data <= drop_wdata;
  end

  swad_ram #(.WIDTH(CNT_W), .DEPTH(ALPHABET)) u_net_c (
    .clk(clk), .we(commit && net_we), .waddr(s2_bin), .wdata(net_wdata),
    .re(1'b1), .raddr(rd_c), .rdata(net_c_rdata)
  );

  swad_ram #(.WIDTH(CNT_W), .DEPTH(ALPHABET)) u_net_o (
    .clk(clk), .we(commit && net_we), .waddr(s2_bin), .wdata(net_wdata),
    .re(1'b1), .raddr(rd_o), .rdata(net_o_rdata)
  );

  swad_ram #(.WIDTH(CNT_W), .DEPTH(ALPHABET)) u_drop_c (
    .clk(clk), .we(commit && drop_we), .waddr(s2_old), .wdata(drop_wdata),
    .re(1'b1), .raddr(rd_c), .rdata(drop_c_rdata)
  );

  swad_ram #(.WIDTH(CNT_W), .DEPTH(ALPHABET)) u_drop_o (
    .clk(clk), .we(commit && drop_we), .waddr(s2_old), .wdata(drop_wdata),
    .re(1'b1), .raddr(rd_o), .rdata(drop_o_rdata)
  );

endmodule

// ===== rtl/core/sliding_window_anagram_detector_unit.sv =====
// Sliding-window anagram detector. Every accepted beat (clear, pattern letter,
// text letter or an ignored item) yields exactly one result beat; a new beat is
// taken every cycle while the output is not stalled. The first stage keeps the
// lengths and the ring of window letters and reads the letter leaving the window
// from the ring memory; the second reads the histogram memories, which hold
// per-bin counts of window entries less pattern letters and of exits, updates
// the count of differing bins and writes back, with a one-deep bypass for a bin
// written on the cycle before; the third registers the result. A clear takes
// effect at once via per-bin valid bits: no clearing pass after reset or clear.
module sliding_window_anagram_detector_unit #(
  parameter int MAX_PATTERN = 64,
  parameter int ALPHABET    = 26
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  swad_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output swad_pkg::result_t result
);

  localparam int BIN_W = $clog2(ALPHABET);

  logic              advance, accept;
  logic              s1_valid, s2_valid;
  swad_pkg::ctl_t    s1_ctl;
  logic [BIN_W-1:0]  s1_bin, s1_old;
  swad_pkg::result_t res;

  assign advance    = !result_valid || !result_stall;
  assign accept     = item_valid && advance;
  assign item_stall = !advance;

  swad_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .ALPHABET    (ALPHABET)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .accept   (accept),
    .item     (item),
    .s1_valid (s1_valid),
    .s1_ctl   (s1_ctl),
    .s1_bin   (s1_bin),
    .s1_old   (s1_old)
  );

  swad_hist #(
    .MAX_PATTERN (MAX_PATTERN),
    .ALPHABET    (ALPHABET)
  ) u_hist (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_ctl   (s1_ctl),
    .s1_bin   (s1_bin),
    .s1_old   (s1_old),
    .s2_valid (s2_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

endmodule

// ===== rtl/core/swad_checker.sv =====
module swad_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input swad_pkg::result_t result
);

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result beat shown right after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    !(result_valid && result_stall) |-> !item_stall)
    else $error("input stalled while the output can move");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> item_stall)
    else $error("input taken while the output is stalled");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall ##1 !result_stall ##1 !result_stall |=> result_valid)
    else $error("accepted beat did not reach the output in three cycles");

endmodule

bind sliding_window_anagram_detector_unit swad_checker u_swad_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ===== bench/tb_sliding_window_anagram_detector_unit.sv =====
module tb_sliding_window_anagram_detector_unit;

  localparam int MAX_PATTERN = 64;
  localparam int ALPHABET = 26;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_BEATS = 750;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  // Tracks the detector state and holds the status beats that are due back.
  class status_board;
    logic [6:0] pat_hist [ALPHABET];
    logic [6:0] win_hist [ALPHABET];
    logic [4:0] ring [MAX_PATTERN];
    int pat_len;
    int win_fill;
    int head;
    int diff_bins;
    bit found;
    bit ovf;
    swad_pkg::result_t expected_status [$];
    int errors;

    function new();
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < ALPHABET; i++) begin
        pat_hist[i] = '0;
        win_hist[i] = '0;
      end
      pat_len = 0;
      win_fill = 0;
      head = 0;
      diff_bins = 0;
      found = 1'b0;
      ovf = 1'b0;
    endfunction

    function void adjust(bit in_pattern, int bin, bit up);
      bit was;
      bit now;
      was = pat_hist[bin] != win_hist[bin];
      if (in_pattern) begin
        pat_hist[bin] = pat_hist[bin] + 7'd1;
      end else if (up) begin
        win_hist[bin] = win_hist[bin] + 7'd1;
      end else if (win_hist[bin] != 7'd0) begin
        win_hist[bin] = win_hist[bin] - 7'd1;
      end
      now = pat_hist[bin] != win_hist[bin];
      if (was && !now) begin
        diff_bins--;
      end else if (!was && now) begin
        diff_bins++;
      end
    endfunction

    function void note_beat(swad_pkg::item_t beat);
      swad_pkg::result_t due;
      int slot;
      if (beat.action == swad_pkg::ACT_CLEAR) begin
        wipe();
      end else if ((beat.action == swad_pkg::ACT_PATTERN ||
                    beat.action == swad_pkg::ACT_TEXT) &&
                   beat.letter < ALPHABET) begin
        if (beat.action == swad_pkg::ACT_PATTERN) begin
          if (pat_len >= MAX_PATTERN) begin
            ovf = 1'b1;
          end else begin
            pat_len++;
            adjust(1'b1, int'(beat.letter), 1'b1);
          end
        end else if (pat_len != 0) begin
          slot = (head + win_fill) % MAX_PATTERN;
          if (win_fill >= pat_len) begin
            adjust(1'b0, int'(ring[head]), 1'b0);
            ring[slot] = beat.letter;
            adjust(1'b0, int'(beat.letter), 1'b1);
            head = (head + 1) % MAX_PATTERN;
          end else begin
            ring[slot] = beat.letter;
            adjust(1'b0, int'(beat.letter), 1'b1);
            win_fill++;
          end
        end
        if (diff_bins == 0) begin
          found = 1'b1;
        end
      end
      due.window_match = (diff_bins == 0);
      due.found_any = found;
      due.pattern_overflow = ovf;
      expected_status.push_back(due);
    endfunction

    function void check_result(swad_pkg::result_t got);
      swad_pkg::result_t due;
      if (expected_status.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result beat: expected none, got %b", got);
        end
      end else begin
        due = expected_status.pop_front();
        if (got.window_match !== due.window_match || got.found_any !== due.found_any ||
            got.pattern_overflow !== due.pattern_overflow) begin
          errors++;
          if (errors <= 10) begin
            $display("result mismatch: expected match=%b found=%b overflow=%b, got %b %b %b",
                     due.window_match, due.found_any, due.pattern_overflow,
                     got.window_match, got.found_any, got.pattern_overflow);
          end
        end
      end
    endfunction

    function int pending();
      return expected_status.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  swad_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  swad_pkg::result_t result;

  status_board board = new();
  bit idle_off = 1'b0;
  int stall_left = 0;
  int beats_sent = 0;
  int cycles = 0;

  sliding_window_anagram_detector_unit #(
    .MAX_PATTERN(MAX_PATTERN),
    .ALPHABET(ALPHABET)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[sliding_window_anagram_detector_unit] ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 50) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 10));
    return int'($urandom_range(20, 60));
  endfunction

  function automatic logic [4:0] pick_letter(int base, int size, bit wide);
    if (wide) return 5'($urandom_range(0, ALPHABET - 1));
    return 5'(base + int'($urandom_range(0, size - 1)));
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        board.check_result(result);
      end
      if (stall_left > 0 && !idle_off) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
        stall_left = (idle_off || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
      end
    end
  end

  task automatic send_beat(input logic [1:0] act, input logic [4:0] ltr);
    swad_pkg::item_t beat;
    int gap;
    beat.action = act;
    beat.letter = ltr;
    gap = idle_off ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= beat;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    board.note_beat(beat);
    if (act == swad_pkg::ACT_CLEAR ||
        ((act == swad_pkg::ACT_PATTERN || act == swad_pkg::ACT_TEXT) && ltr < ALPHABET)) begin
      beats_sent++;
    end
  endtask

  task automatic send_junk();
    if ($urandom_range(0, 1) == 0) begin
      send_beat(ACT_SPARE, 5'($urandom_range(0, 31)));
    end else begin
      send_beat($urandom_range(0, 1) ? swad_pkg::ACT_PATTERN : swad_pkg::ACT_TEXT,
                5'($urandom_range(ALPHABET, 31)));
    end
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic run_sequence(input int idx);
    int plen;
    int tlen;
    int base;
    int size;
    int r;
    bit wide;
    bit broken;
    r = $urandom_range(0, 99);
    idle_off = ($urandom_range(0, 4) == 0);
    if (idx == 0) begin
      plen = MAX_PATTERN + 2;
    end else if (r < 70) begin
      plen = $urandom_range(1, 6);
    end else if (r < 85) begin
      plen = $urandom_range(7, 20);
    end else if (r < 95) begin
      plen = MAX_PATTERN;
    end else begin
      plen = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 6);
    end
    base = $urandom_range(0, ALPHABET - 4);
    size = $urandom_range(1, 4);
    wide = ($urandom_range(0, 9) == 0);
    broken = ($urandom_range(0, 4) == 0);
    if (idx == 0 || $urandom_range(0, 9) != 0) begin
      send_beat(swad_pkg::ACT_CLEAR, 5'($urandom_range(0, 31)));
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) send_beat(swad_pkg::ACT_TEXT, pick_letter(base, size, wide));
    end
    for (int k = 0; k < plen; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_junk();
      end
      send_beat(swad_pkg::ACT_PATTERN, pick_letter(base, size, wide));
    end
    tlen = (plen > MAX_PATTERN ? MAX_PATTERN : plen) + $urandom_range(5, 30);
    for (int k = 0; k < tlen; k++) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_junk();
      end else if (r < 8) begin
        send_beat(swad_pkg::ACT_PATTERN, pick_letter(base, size, wide));
      end
      send_beat(swad_pkg::ACT_TEXT, pick_letter(base, size, wide || broken));
    end
    if (idx % 8 == 7) begin
      drain_results();
    end
  endtask

  initial begin
    int idx;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_beat(swad_pkg::ACT_CLEAR, 5'd31);
    send_beat(swad_pkg::ACT_TEXT, 5'd0);
    send_beat(ACT_SPARE, 5'd5);
    send_beat(swad_pkg::ACT_PATTERN, 5'd0);
    send_beat(swad_pkg::ACT_PATTERN, 5'd25);
    send_beat(swad_pkg::ACT_PATTERN, 5'd31);
    send_beat(swad_pkg::ACT_TEXT, 5'd25);
    send_beat(swad_pkg::ACT_TEXT, 5'd26);
    send_beat(swad_pkg::ACT_TEXT, 5'd0);
    send_beat(swad_pkg::ACT_TEXT, 5'd0);
    send_beat(swad_pkg::ACT_TEXT, 5'd25);
    send_beat(swad_pkg::ACT_PATTERN, 5'd1);
    send_beat(swad_pkg::ACT_TEXT, 5'd1);
    send_beat(ACT_SPARE, 5'd0);
    send_beat(swad_pkg::ACT_CLEAR, 5'd0);
    send_beat(swad_pkg::ACT_PATTERN, 5'd16);
    send_beat(swad_pkg::ACT_TEXT, 5'd15);
    send_beat(swad_pkg::ACT_TEXT, 5'd16);
    send_beat(swad_pkg::ACT_CLEAR, 5'd10);
    drain_results();

    beats_sent = 0;
    idx = 0;
    while (beats_sent < RANDOM_BEATS) begin
      run_sequence(idx);
      idx++;
    end
    idle_off = 1'b0;
    drain_results();
    repeat (10) @(posedge clk);

    board.errors += board.pending();
    if (board.errors == 0) begin
      $display("[sliding_window_anagram_detector_unit] OK");
    end else begin
      $display("[sliding_window_anagram_detector_unit] ERROR");
    end
    $finish;
  end

endmodule
